// ===== rtl/bdpc_pkg.sv =====
// Package for the button debounce / press classifier.
// Holds the shared types, event codes, register indexes and defaults.
// No dependencies.
package bdpc_pkg;

  localparam int unsigned NumButtonsDef = 4;
  localparam int unsigned IndexW        = 2;
  localparam int unsigned CntW          = 8;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 8;

  localparam logic [CntW-1:0] StrokeThrRst = 8'd4;
  localparam logic [CntW-1:0] ShortThrRst  = 8'd5;
  localparam logic [CntW-1:0] LongThrRst   = 8'd100;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_EARLY_REL = 3'd1,
    EV_SHORT_HIT = 3'd2,
    EV_LONG_HIT  = 3'd3,
    EV_SHORT_REL = 3'd4,
    EV_LONG_REL  = 3'd5
  } press_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STROKE_THR = 2'd0,
    REG_SHORT_THR  = 2'd1,
    REG_LONG_THR   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CntW-1:0] stroke_thr;
    logic [CntW-1:0] short_thr;
    logic [CntW-1:0] long_thr;
  } thresholds_t;

  typedef struct packed {
    logic [IndexW-1:0] button_index;
    logic              button_level;
    logic              debounce_tick;
    logic              classify_tick;
  } in_item_t;

  typedef struct packed {
    logic         stable_pressed;
    press_event_e press_event;
  } out_item_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/bdpc_if.sv =====
// Valid/ready channel interfaces for the press classifier.
// Depends on bdpc_pkg for field widths.
interface bdpc_in_if import bdpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] button_index;
  logic              button_level;
  logic              debounce_tick;
  logic              classify_tick;

  modport source (output valid, button_index, button_level, debounce_tick, classify_tick,
                  input ready);
  modport sink   (input valid, button_index, button_level, debounce_tick, classify_tick,
                  output ready);
endinterface

interface bdpc_out_if ();
  logic       valid;
  logic       ready;
  logic       stable_pressed;
  logic [2:0] press_event;

  modport source (output valid, stable_pressed, press_event, input ready);
  modport sink   (input valid, stable_pressed, press_event, output ready);
endinterface

// ===== rtl/bdpc_cfg_regs.sv =====
// Threshold configuration registers for the press classifier.
// Depends on bdpc_pkg.
module bdpc_cfg_regs import bdpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] wdata_i,
  output thresholds_t         thr_o
);

  thresholds_t thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.stroke_thr <= StrokeThrRst;
      thr_q.short_thr  <= ShortThrRst;
      thr_q.long_thr   <= LongThrRst;
    end else if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        REG_STROKE_THR: thr_q.stroke_thr <= wdata_i[CntW-1:0];
        REG_SHORT_THR:  thr_q.short_thr  <= wdata_i[CntW-1:0];
        REG_LONG_THR:   thr_q.long_thr   <= wdata_i[CntW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign thr_o = thr_q;

endmodule

// ===== rtl/bdpc_core.sv =====
// Per-button debounce and hold-time state plus the single-pass update logic.
// Depends on bdpc_pkg.
module bdpc_core import bdpc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,    // commit the item's state update
  input  in_item_t    item_i,
  input  thresholds_t thr_i,
  output out_item_t   res_o
);

  localparam int unsigned BtnW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [NUM_BUTTONS-1:0][CntW-1:0] db_cnt_q, hold_cnt_q;
  logic [NUM_BUTTONS-1:0]           stable_q, short_seen_q, long_seen_q;

  logic            in_range;
  logic [BtnW-1:0] sel;
  logic [CntW-1:0] db_cnt, db_cnt_d, hold_cnt, hold_cnt_d;
  logic            stable, stable_d, short_seen, short_seen_d, long_seen, long_seen_d;
  logic [CntW-1:0] hold_inc;
  press_event_e    ev;

  assign in_range = 32'(item_i.button_index) < 32'(NUM_BUTTONS);
  assign sel      = BtnW'(item_i.button_index);

  assign db_cnt     = db_cnt_q[sel];
  assign stable     = stable_q[sel];
  assign hold_cnt   = hold_cnt_q[sel];
  assign short_seen = short_seen_q[sel];
  assign long_seen  = long_seen_q[sel];
  assign hold_inc   = sat_inc(hold_cnt);

  // debounce, then classify on the freshly debounced flag
  always_comb begin
    db_cnt_d     = db_cnt;
    stable_d     = stable;
    hold_cnt_d   = hold_cnt;
    short_seen_d = short_seen;
    long_seen_d  = long_seen;
    ev           = EV_NONE;

    if (item_i.debounce_tick) begin
      if (item_i.button_level) begin
        if (!stable) begin
          db_cnt_d = sat_inc(db_cnt);
          stable_d = (db_cnt_d >= thr_i.stroke_thr);
        end
      end else if (stable) begin
        if (db_cnt <= 8'd1) begin
          db_cnt_d = '0;
          stable_d = 1'b0;
        end else begin
          db_cnt_d = db_cnt - 1'b1;
        end
      end
    end

    if (item_i.classify_tick) begin
      if (stable_d) begin
        if (!short_seen) begin
          hold_cnt_d = hold_inc;
          if (hold_inc >= thr_i.short_thr) begin
            short_seen_d = 1'b1;
            ev           = EV_SHORT_HIT;
          end
        end else if (!long_seen) begin
          hold_cnt_d = hold_inc;
          if (hold_inc >= thr_i.long_thr) begin
            long_seen_d = 1'b1;
            ev          = EV_LONG_HIT;
          end
        end
      end else if (hold_cnt != '0) begin
        if (long_seen)       ev = EV_LONG_REL;
        else if (short_seen) ev = EV_SHORT_REL;
        else                 ev = EV_EARLY_REL;
        hold_cnt_d   = '0;
        short_seen_d = 1'b0;
        long_seen_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_cnt_q     <= '0;
      hold_cnt_q   <= '0;
      stable_q     <= '0;
      short_seen_q <= '0;
      long_seen_q  <= '0;
    end else if (step_i && in_range) begin
      db_cnt_q[sel]     <= db_cnt_d;
      hold_cnt_q[sel]   <= hold_cnt_d;
      stable_q[sel]     <= stable_d;
      short_seen_q[sel] <= short_seen_d;
      long_seen_q[sel]  <= long_seen_d;
    end
  end

  assign res_o.stable_pressed = in_range & stable_d;
  assign res_o.press_event    = in_range ? ev : EV_NONE;

endmodule

// ===== rtl/button_debounce_press_classifier.sv =====
// An accepted transaction is held in the input register and then in the result register, which drives the output.
// Throughput: one transaction per cycle, sustained while out_o.ready does not stall the result register,
//   also for the same button back to back; the per-button state is read and rewritten
//   combinationally between the input register and the result register.
// Reset (rst_ni, async low): all per-button counters and flags cleared, thresholds
//   back to 4 / 5 / 100, both pipeline stages empty.
module button_debounce_press_classifier import bdpc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bdpc_in_if.sink             in_i,
  bdpc_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  thresholds_t thr;

  // Stage 1: input register holding the accepted transaction.
  logic      s1_vld_q;
  in_item_t  s1_item_q;
  // Stage 2: result register; the skid between core and consumer.
  logic      out_vld_q;
  out_item_t out_item_q;

  out_item_t res;
  logic      out_free;   // result register can take a new value this cycle
  logic      s1_move;    // stage 1 retires into the result register
  logic      in_take;

  assign out_free = !out_vld_q || out_o.ready;
  assign s1_move  = s1_vld_q && out_free;
  assign in_take  = in_i.valid && in_i.ready;
  // Stage 1 can reload whenever it empties in the same cycle.
  assign in_i.ready = !s1_vld_q || out_free;

  bdpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .thr_o   (thr)
  );

  // State is committed only when the transaction leaves stage 1, so a stalled
  // item never updates its button twice.
  bdpc_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_move),
    .item_i (s1_item_q),
    .thr_i  (thr),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.button_index  <= in_i.button_index;
      s1_item_q.button_level  <= in_i.button_level;
      s1_item_q.debounce_tick <= in_i.debounce_tick;
      s1_item_q.classify_tick <= in_i.classify_tick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.stable_pressed = out_item_q.stable_pressed;
  assign out_o.press_event    = out_item_q.press_event;

endmodule

// ===== rtl/bdpc_checker.sv =====
// Port-level checks for the press classifier, bound to the top level.
// Depends on bdpc_pkg for the event codes.
module bdpc_checker import bdpc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       stable_pressed_i,
  input logic [2:0] press_event_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(press_event_i) &&
      $stable(stable_pressed_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> press_event_i <= EV_LONG_REL)
    else $error("undefined event code");

  // reached events come only while the button is debounced as pressed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (press_event_i == EV_SHORT_HIT || press_event_i == EV_LONG_HIT)
      |-> stable_pressed_i)
    else $error("hold event on a released button");

  // release events come only once the button is debounced as released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (press_event_i == EV_EARLY_REL || press_event_i == EV_SHORT_REL ||
                    press_event_i == EV_LONG_REL) |-> !stable_pressed_i)
    else $error("release event on a pressed button");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .stable_pressed_i (out_o.stable_pressed),
  .press_event_i    (out_o.press_event)
);
